/* rtl/pft_pkg.sv */
// Shared types, constants and rounding helpers for the pose frame transform.
// No dependencies; imported by pose_frame_transform.
`default_nettype none

package pft_pkg;

    // Iteration counts of the pipelined units
    localparam int DIV1_STEPS  = 31;   // matrix entry divider, quotient bits
    localparam int SQRT_STEPS  = 32;   // integer square root, result bits
    localparam int DIV2_STEPS  = 15;   // quaternion normalizer, quotient bits

    // Fixed-point one of the composed matrix (Q.24)
    localparam logic signed [33:0] B_ONE = 34'sd16777216;

    // Output quaternion limits (Q1.14)
    localparam logic [14:0] Q_ONE = 15'd16384;

    // Configuration register map
    typedef enum logic [2:0] {
        REG_ROT_ROW0  = 3'd0,
        REG_ROT_ROW1  = 3'd1,
        REG_ROT_ROW2  = 3'd2,
        REG_OFFSET_X  = 3'd3,
        REG_OFFSET_Y  = 3'd4,
        REG_OFFSET_Z  = 3'd5,
        REG_ROT_TWIST = 3'd6
    } reg_idx_t;

    // Item kinds
    localparam logic KIND_POSE = 1'b0;
    localparam logic KIND_VEC  = 1'b1;

    // Side data that travels with each item down the pipeline
    typedef struct packed {
        logic             kind;
        logic [2:0][31:0] vec;    // input vector, later the finished position
    } side_t;

    // Arithmetic right shift rounded half away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                input int unsigned s);
        logic [63:0] m;
        m = v[63] ? $unsigned(-v) : $unsigned(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // Saturate to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/pose_frame_transform.sv */
// Pose frame transform: sensor-frame pose to body-frame pose, twist rotation.
// Depends on pft_pkg (types, register map, rounding helpers).
`default_nettype none

// One item is taken every clock cycle; busy never rises. Each accepted item
// comes out on the result ports as a one-cycle beat flagged by result_valid,
// in input order. Three bit-per-stage units lie on the path: the 31-stage
// divider that normalizes the nine rotation entries, the 32-stage integer
// square root and the 15-stage divider that normalizes the quaternion. A pose
// whose quaternion is all zero is dropped at the input and gives no beat. The
// receiver cannot stall, so results must be taken in the cycle they appear.
// APB registers sit at byte address 8*i; the user must see that they are
// written only while the pipeline is empty. The block does not enforce it.
module pose_frame_transform (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    // result channel
    output logic             result_valid,
    output logic             result_kind,
    output logic signed [15:0] out_w,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import pft_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0]        rot_row_reg [3];
    logic signed [31:0] offset_reg  [3];
    logic               rotate_twist_reg;
    logic               cfg_wr;
    logic signed [15:0] ext_w [3][3];

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    // Write a register at the end of the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_row_reg[0]   <= 48'h4000_0000_0000;
            rot_row_reg[1]   <= 48'h0000_4000_0000;
            rot_row_reg[2]   <= 48'h0000_0000_4000;
            offset_reg[0]    <= '0;
            offset_reg[1]    <= '0;
            offset_reg[2]    <= '0;
            rotate_twist_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[5:3]))
                REG_ROT_ROW0:  rot_row_reg[0]   <= pwdata[47:0];
                REG_ROT_ROW1:  rot_row_reg[1]   <= pwdata[47:0];
                REG_ROT_ROW2:  rot_row_reg[2]   <= pwdata[47:0];
                REG_OFFSET_X:  offset_reg[0]    <= pwdata[31:0];
                REG_OFFSET_Y:  offset_reg[1]    <= pwdata[31:0];
                REG_OFFSET_Z:  offset_reg[2]    <= pwdata[31:0];
                REG_ROT_TWIST: rotate_twist_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (reg_idx_t'(paddr[5:3]))
            REG_ROT_ROW0:  prdata = {16'd0, rot_row_reg[0]};
            REG_ROT_ROW1:  prdata = {16'd0, rot_row_reg[1]};
            REG_ROT_ROW2:  prdata = {16'd0, rot_row_reg[2]};
            REG_OFFSET_X:  prdata = {32'd0, offset_reg[0]};
            REG_OFFSET_Y:  prdata = {32'd0, offset_reg[1]};
            REG_OFFSET_Z:  prdata = {32'd0, offset_reg[2]};
            REG_ROT_TWIST: prdata = {63'd0, rotate_twist_reg};
            default:       prdata = '0;
        endcase
    end

    // Unpack extrinsic entries, column 0 in the top bits
    always_comb
    begin
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
                ext_w[j][k] = $signed(rot_row_reg[j][47 - 16*k -: 16]);
    end

    // ------------------------------------------------------------------
    // Stage A: accept, quaternion and twist products
    // ------------------------------------------------------------------
    logic               in_acc;
    logic               a_vld_reg;
    side_t              a_side_reg;
    logic signed [31:0] a_ww_reg, a_xx_reg, a_yy_reg, a_zz_reg;
    logic signed [31:0] a_xy_reg, a_wz_reg, a_xz_reg, a_wy_reg, a_yz_reg, a_wx_reg;
    logic signed [47:0] a_vp_reg [3][3];
    logic signed [31:0] vin_w [3];

    assign busy   = 1'b0;
    assign in_acc = start & ~busy;
    assign vin_w[0] = vec_x;
    assign vin_w[1] = vec_y;
    assign vin_w[2] = vec_z;

    // Drop a pose whose quaternion is all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= in_acc & (kind |
                         (|{quat_w, quat_x, quat_y, quat_z}));
    end

    always_ff @(posedge clk)
    begin
        a_side_reg.kind <= kind;
        a_side_reg.vec  <= {vec_z, vec_y, vec_x};
        a_ww_reg <= 32'(quat_w) * 32'(quat_w);
        a_xx_reg <= 32'(quat_x) * 32'(quat_x);
        a_yy_reg <= 32'(quat_y) * 32'(quat_y);
        a_zz_reg <= 32'(quat_z) * 32'(quat_z);
        a_xy_reg <= 32'(quat_x) * 32'(quat_y);
        a_wz_reg <= 32'(quat_w) * 32'(quat_z);
        a_xz_reg <= 32'(quat_x) * 32'(quat_z);
        a_wy_reg <= 32'(quat_w) * 32'(quat_y);
        a_yz_reg <= 32'(quat_y) * 32'(quat_z);
        a_wx_reg <= 32'(quat_w) * 32'(quat_x);
        for (int j = 0; j < 3; j++)
            for (int k = 0; k < 3; k++)
                a_vp_reg[j][k] <= 48'(ext_w[j][k]) * 48'(vin_w[k]);
    end

    // ------------------------------------------------------------------
    // Stage B: norm, matrix numerators, twist rotation; loads the divider
    // ------------------------------------------------------------------
    logic signed [33:0] b_nsum;
    logic [32:0]        b_n;
    logic signed [33:0] b_num [9];
    logic [33:0]        b_mag [9];
    side_t              b_side;
    logic signed [63:0] b_vsum [3];

    always_comb
    begin
        b_nsum = 34'(a_ww_reg) + 34'(a_xx_reg) + 34'(a_yy_reg) + 34'(a_zz_reg);
        b_n    = b_nsum[32:0];
        // row-major numerators of the rotation matrix
        b_num[0] = 34'(a_ww_reg) + 34'(a_xx_reg) - 34'(a_yy_reg) - 34'(a_zz_reg);
        b_num[1] = (34'(a_xy_reg) - 34'(a_wz_reg)) <<< 1;
        b_num[2] = (34'(a_xz_reg) + 34'(a_wy_reg)) <<< 1;
        b_num[3] = (34'(a_xy_reg) + 34'(a_wz_reg)) <<< 1;
        b_num[4] = 34'(a_ww_reg) - 34'(a_xx_reg) + 34'(a_yy_reg) - 34'(a_zz_reg);
        b_num[5] = (34'(a_yz_reg) - 34'(a_wx_reg)) <<< 1;
        b_num[6] = (34'(a_xz_reg) - 34'(a_wy_reg)) <<< 1;
        b_num[7] = (34'(a_yz_reg) + 34'(a_wx_reg)) <<< 1;
        b_num[8] = 34'(a_ww_reg) - 34'(a_xx_reg) - 34'(a_yy_reg) + 34'(a_zz_reg);
        for (int l = 0; l < 9; l++)
            b_mag[l] = b_num[l][33] ? $unsigned(-b_num[l]) : $unsigned(b_num[l]);
        // rotate twist vectors when enabled
        b_side = a_side_reg;
        for (int j = 0; j < 3; j++)
        begin
            b_vsum[j] = 64'(a_vp_reg[j][0]) + 64'(a_vp_reg[j][1])
                      + 64'(a_vp_reg[j][2]);
            if (a_side_reg.kind == KIND_VEC && rotate_twist_reg)
                b_side.vec[j] = sat32(rshr(b_vsum[j], 14));
        end
    end

    // ------------------------------------------------------------------
    // Divider 1: nine lanes of round(num * 2^30 / n), one bit per stage
    // ------------------------------------------------------------------
    logic        d1_vld_reg  [DIV1_STEPS+1];
    side_t       d1_side_reg [DIV1_STEPS+1];
    logic [33:0] d1_den_reg  [DIV1_STEPS+1];
    logic [63:0] d1_rem_reg  [DIV1_STEPS+1][9];
    logic [30:0] d1_quo_reg  [DIV1_STEPS+1][9];
    logic        d1_sgn_reg  [DIV1_STEPS+1][9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d1_vld_reg[0] <= 1'b0;
        else
            d1_vld_reg[0] <= a_vld_reg;
    end

    // Load dividend (|num| << 31) + n and divisor 2n
    always_ff @(posedge clk)
    begin
        d1_side_reg[0] <= b_side;
        d1_den_reg[0]  <= {b_n, 1'b0};
        for (int l = 0; l < 9; l++)
        begin
            d1_rem_reg[0][l] <= {b_mag[l][32:0], 31'd0} + 64'(b_n);
            d1_quo_reg[0][l] <= '0;
            d1_sgn_reg[0][l] <= b_num[l][33];
        end
    end

    for (genvar s = 0; s < DIV1_STEPS; s++)
    begin : g_div1
        localparam int SH = DIV1_STEPS - 1 - s;
        logic [63:0] trial;

        assign trial = 64'(d1_den_reg[s]) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d1_vld_reg[s+1] <= 1'b0;
            else
                d1_vld_reg[s+1] <= d1_vld_reg[s];
        end

        // Subtract the shifted divisor where it fits
        always_ff @(posedge clk)
        begin
            d1_side_reg[s+1] <= d1_side_reg[s];
            d1_den_reg[s+1]  <= d1_den_reg[s];
            for (int l = 0; l < 9; l++)
            begin
                d1_sgn_reg[s+1][l] <= d1_sgn_reg[s][l];
                if (d1_rem_reg[s][l] >= trial)
                begin
                    d1_rem_reg[s+1][l] <= d1_rem_reg[s][l] - trial;
                    d1_quo_reg[s+1][l] <= {d1_quo_reg[s][l][29:0], 1'b1};
                end
                else
                begin
                    d1_rem_reg[s+1][l] <= d1_rem_reg[s][l];
                    d1_quo_reg[s+1][l] <= {d1_quo_reg[s][l][29:0], 1'b0};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage M: R * E^T partial products
    // ------------------------------------------------------------------
    logic signed [31:0] m_rm [3][3];
    logic               m_vld_reg;
    side_t              m_side_reg;
    logic signed [47:0] m_prod_reg [3][3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                m_rm[i][k] = d1_sgn_reg[DIV1_STEPS][3*i+k]
                           ? -$signed(32'(d1_quo_reg[DIV1_STEPS][3*i+k]))
                           :  $signed(32'(d1_quo_reg[DIV1_STEPS][3*i+k]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else
            m_vld_reg <= d1_vld_reg[DIV1_STEPS];
    end

    always_ff @(posedge clk)
    begin
        m_side_reg <= d1_side_reg[DIV1_STEPS];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    m_prod_reg[i][j][k] <= 48'(m_rm[i][k]) * 48'(ext_w[j][k]);
    end

    // ------------------------------------------------------------------
    // Stage S: sum and round the composed matrix to Q.24
    // ------------------------------------------------------------------
    logic               s_vld_reg;
    side_t              s_side_reg;
    logic signed [31:0] s_b_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= 1'b0;
        else
            s_vld_reg <= m_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        s_side_reg <= m_side_reg;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                s_b_reg[i][j] <= 32'(rshr(64'(m_prod_reg[i][j][0])
                                        + 64'(m_prod_reg[i][j][1])
                                        + 64'(m_prod_reg[i][j][2]), 20));
    end

    // ------------------------------------------------------------------
    // Stage P: B * t products, Shepperd selection
    // ------------------------------------------------------------------
    logic signed [33:0] p_tr;
    logic signed [33:0] p_c [4];
    logic [1:0]         p_i, p_j, p_k;
    logic               p_vld_reg;
    side_t              p_side_reg;
    logic signed [63:0] p_bt_reg [3][3];
    logic [31:0]        p_cmag_reg [4];
    logic               p_csgn_reg [4];

    always_comb
    begin
        p_tr = 34'(s_b_reg[0][0]) + 34'(s_b_reg[1][1]) + 34'(s_b_reg[2][2]);
        p_i  = 2'd0;
        p_j  = 2'd1;
        p_k  = 2'd2;
        for (int n = 0; n < 4; n++)
            p_c[n] = '0;
        if (p_tr > 0)
        begin
            p_c[0] = p_tr + B_ONE;
            p_c[1] = 34'(s_b_reg[2][1]) - 34'(s_b_reg[1][2]);
            p_c[2] = 34'(s_b_reg[0][2]) - 34'(s_b_reg[2][0]);
            p_c[3] = 34'(s_b_reg[1][0]) - 34'(s_b_reg[0][1]);
        end
        else
        begin
            // largest diagonal, ties keep the lower index
            if (s_b_reg[1][1] > s_b_reg[0][0])
                p_i = 2'd1;
            if (s_b_reg[2][2] > s_b_reg[p_i][p_i])
                p_i = 2'd2;
            case (p_i)
                2'd0:
                begin
                    p_j = 2'd1;
                    p_k = 2'd2;
                end
                2'd1:
                begin
                    p_j = 2'd2;
                    p_k = 2'd0;
                end
                default:
                begin
                    p_j = 2'd0;
                    p_k = 2'd1;
                end
            endcase
            p_c[p_i + 2'd1] = 34'(s_b_reg[p_i][p_i]) - 34'(s_b_reg[p_j][p_j])
                            - 34'(s_b_reg[p_k][p_k]) + B_ONE;
            p_c[0]          = 34'(s_b_reg[p_k][p_j]) - 34'(s_b_reg[p_j][p_k]);
            p_c[p_j + 2'd1] = 34'(s_b_reg[p_j][p_i]) + 34'(s_b_reg[p_i][p_j]);
            p_c[p_k + 2'd1] = 34'(s_b_reg[p_k][p_i]) + 34'(s_b_reg[p_i][p_k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else
            p_vld_reg <= s_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        p_side_reg <= s_side_reg;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                p_bt_reg[i][k] <= 64'(s_b_reg[i][k]) * 64'(offset_reg[k]);
        for (int n = 0; n < 4; n++)
        begin
            p_csgn_reg[n] <= p_c[n][33];
            p_cmag_reg[n] <= p_c[n][33] ? 32'($unsigned(-p_c[n]))
                                        : 32'($unsigned(p_c[n]));
        end
    end

    // ------------------------------------------------------------------
    // Stage Q: body position, squared quaternion terms
    // ------------------------------------------------------------------
    logic signed [63:0] q_pos [3];
    side_t              q_side;
    logic               q_vld_reg;
    side_t              q_side_reg;
    logic [63:0]        q_sq_reg   [4];
    logic [31:0]        q_cmag_reg [4];
    logic               q_csgn_reg [4];

    always_comb
    begin
        q_side = p_side_reg;
        for (int i = 0; i < 3; i++)
        begin
            q_pos[i] = 64'($signed(p_side_reg.vec[i]))
                     - rshr(p_bt_reg[i][0] + p_bt_reg[i][1] + p_bt_reg[i][2], 24);
            if (p_side_reg.kind == KIND_POSE)
                q_side.vec[i] = sat32(q_pos[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_vld_reg <= 1'b0;
        else
            q_vld_reg <= p_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        q_side_reg <= q_side;
        for (int n = 0; n < 4; n++)
        begin
            q_sq_reg[n]   <= 64'(p_cmag_reg[n]) * 64'(p_cmag_reg[n]);
            q_cmag_reg[n] <= p_cmag_reg[n];
            q_csgn_reg[n] <= p_csgn_reg[n];
        end
    end

    // ------------------------------------------------------------------
    // Square root: floor(sqrt(sum of squares)), one result bit per stage
    // ------------------------------------------------------------------
    logic        sr_vld_reg  [SQRT_STEPS+1];
    side_t       sr_side_reg [SQRT_STEPS+1];
    logic [63:0] sr_n_reg    [SQRT_STEPS+1];
    logic [63:0] sr_res_reg  [SQRT_STEPS+1];
    logic [31:0] sr_cmag_reg [SQRT_STEPS+1][4];
    logic        sr_csgn_reg [SQRT_STEPS+1][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sr_vld_reg[0] <= 1'b0;
        else
            sr_vld_reg[0] <= q_vld_reg;
    end

    // Sum the squares into the root's radicand
    always_ff @(posedge clk)
    begin
        sr_side_reg[0] <= q_side_reg;
        sr_n_reg[0]    <= q_sq_reg[0] + q_sq_reg[1] + q_sq_reg[2] + q_sq_reg[3];
        sr_res_reg[0]  <= '0;
        for (int n = 0; n < 4; n++)
        begin
            sr_cmag_reg[0][n] <= q_cmag_reg[n];
            sr_csgn_reg[0][n] <= q_csgn_reg[n];
        end
    end

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        localparam int SH = 2*SQRT_STEPS - 2 - 2*s;
        logic [63:0] bitv;
        logic [63:0] trial;

        assign bitv  = 64'd1 << SH;
        assign trial = sr_res_reg[s] + bitv;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sr_vld_reg[s+1] <= 1'b0;
            else
                sr_vld_reg[s+1] <= sr_vld_reg[s];
        end

        // Take the trial bit where the remainder allows it
        always_ff @(posedge clk)
        begin
            sr_side_reg[s+1] <= sr_side_reg[s];
            for (int n = 0; n < 4; n++)
            begin
                sr_cmag_reg[s+1][n] <= sr_cmag_reg[s][n];
                sr_csgn_reg[s+1][n] <= sr_csgn_reg[s][n];
            end
            if (sr_n_reg[s] >= trial)
            begin
                sr_n_reg[s+1]   <= sr_n_reg[s] - trial;
                sr_res_reg[s+1] <= (sr_res_reg[s] >> 1) + bitv;
            end
            else
            begin
                sr_n_reg[s+1]   <= sr_n_reg[s];
                sr_res_reg[s+1] <= sr_res_reg[s] >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider 2: four lanes of round(c * 2^14 / s), one bit per stage
    // ------------------------------------------------------------------
    logic [31:0] sr_root;
    logic        d2_vld_reg  [DIV2_STEPS+1];
    side_t       d2_side_reg [DIV2_STEPS+1];
    logic        d2_zero_reg [DIV2_STEPS+1];
    logic [32:0] d2_den_reg  [DIV2_STEPS+1];
    logic [47:0] d2_rem_reg  [DIV2_STEPS+1][4];
    logic [14:0] d2_quo_reg  [DIV2_STEPS+1][4];
    logic        d2_sgn_reg  [DIV2_STEPS+1][4];

    assign sr_root = sr_res_reg[SQRT_STEPS][31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d2_vld_reg[0] <= 1'b0;
        else
            d2_vld_reg[0] <= sr_vld_reg[SQRT_STEPS];
    end

    // Load dividend (|c| << 15) + s and divisor 2s
    always_ff @(posedge clk)
    begin
        d2_side_reg[0] <= sr_side_reg[SQRT_STEPS];
        d2_zero_reg[0] <= (sr_root == '0);
        d2_den_reg[0]  <= {sr_root, 1'b0};
        for (int n = 0; n < 4; n++)
        begin
            d2_rem_reg[0][n] <= 48'({sr_cmag_reg[SQRT_STEPS][n], 15'd0}) + 48'(sr_root);
            d2_quo_reg[0][n] <= '0;
            d2_sgn_reg[0][n] <= sr_csgn_reg[SQRT_STEPS][n];
        end
    end

    for (genvar s = 0; s < DIV2_STEPS; s++)
    begin : g_div2
        localparam int SH = DIV2_STEPS - 1 - s;
        logic [47:0] trial;

        assign trial = 48'(d2_den_reg[s]) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                d2_vld_reg[s+1] <= 1'b0;
            else
                d2_vld_reg[s+1] <= d2_vld_reg[s];
        end

        // Subtract the shifted divisor where it fits
        always_ff @(posedge clk)
        begin
            d2_side_reg[s+1] <= d2_side_reg[s];
            d2_zero_reg[s+1] <= d2_zero_reg[s];
            d2_den_reg[s+1]  <= d2_den_reg[s];
            for (int n = 0; n < 4; n++)
            begin
                d2_sgn_reg[s+1][n] <= d2_sgn_reg[s][n];
                if (d2_rem_reg[s][n] >= trial)
                begin
                    d2_rem_reg[s+1][n] <= d2_rem_reg[s][n] - trial;
                    d2_quo_reg[s+1][n] <= {d2_quo_reg[s][n][13:0], 1'b1};
                end
                else
                begin
                    d2_rem_reg[s+1][n] <= d2_rem_reg[s][n];
                    d2_quo_reg[s+1][n] <= {d2_quo_reg[s][n][13:0], 1'b0};
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: clamp, sign, identity fallback, vector zeroing, strobe
    // ------------------------------------------------------------------
    logic [14:0]        o_m [4];
    logic signed [15:0] o_q [4];
    side_t              o_side;
    logic               o_vld_reg;
    logic               o_kind_reg;
    logic signed [15:0] o_q_reg [4];
    logic [2:0][31:0]   o_vec_reg;

    always_comb
    begin
        o_side = d2_side_reg[DIV2_STEPS];
        for (int n = 0; n < 4; n++)
        begin
            o_m[n] = (d2_quo_reg[DIV2_STEPS][n] > Q_ONE) ? Q_ONE
                                                         : d2_quo_reg[DIV2_STEPS][n];
            o_q[n] = d2_sgn_reg[DIV2_STEPS][n] ? -$signed({1'b0, o_m[n]})
                                               :  $signed({1'b0, o_m[n]});
            if (o_side.kind == KIND_VEC)
                o_q[n] = '0;
            else if (d2_zero_reg[DIV2_STEPS])
                o_q[n] = (n == 0) ? $signed({1'b0, Q_ONE}) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_vld_reg <= 1'b0;
        else
            o_vld_reg <= d2_vld_reg[DIV2_STEPS];
    end

    always_ff @(posedge clk)
    begin
        o_kind_reg <= o_side.kind;
        o_vec_reg  <= o_side.vec;
        for (int n = 0; n < 4; n++)
            o_q_reg[n] <= o_q[n];
    end

    assign result_valid = o_vld_reg;
    assign result_kind  = o_kind_reg;
    assign out_w        = o_q_reg[0];
    assign out_x        = o_q_reg[1];
    assign out_y        = o_q_reg[2];
    assign out_z        = o_q_reg[3];
    assign pos_x        = $signed(o_vec_reg[0]);
    assign pos_y        = $signed(o_vec_reg[1]);
    assign pos_z        = $signed(o_vec_reg[2]);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A pose reaching the divider never carries a zero norm
    assert property (@(posedge clk) disable iff (!rst_n)
        (d1_vld_reg[0] && d1_side_reg[0].kind == KIND_POSE) |-> d1_den_reg[0] != '0)
        else $error("zero norm pose entered the matrix divider");

    // Square root result always fits in 32 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        sr_vld_reg[SQRT_STEPS] |-> sr_res_reg[SQRT_STEPS][63:32] == '0)
        else $error("square root overflowed 32 bits");

    // A pose beat always carries a quaternion within unit range
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_POSE) |->
        (out_w <= 16'sd16384 && out_w >= -16'sd16384 &&
         out_x <= 16'sd16384 && out_x >= -16'sd16384 &&
         out_y <= 16'sd16384 && out_y >= -16'sd16384 &&
         out_z <= 16'sd16384 && out_z >= -16'sd16384))
        else $error("pose quaternion out of range");

    // A vector beat carries a zero quaternion
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_kind == KIND_VEC) |->
        (out_w == '0 && out_x == '0 && out_y == '0 && out_z == '0))
        else $error("vector beat with nonzero quaternion");

endmodule

`default_nettype wire

/* dv/pose_frame_transform_test.sv */
// Self-checking testbench for pose_frame_transform: directed table, then random beats.
// Depends on pft_pkg and rtl/pose_frame_transform.sv; the body-frame predictor is built in.
`default_nettype none

module pose_frame_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pft_pkg::*;

    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic        kind;
        logic [15:0] qw, qx, qy, qz;
        logic [31:0] vx, vy, vz;
    } pose_cmd_t;

    typedef struct {
        logic        kind;
        logic [15:0] w, x, y, z;
        logic [31:0] px, py, pz;
    } body_pose_t;

    typedef struct {
        pose_cmd_t  cmd;
        bit         known;
        body_pose_t res;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        kind;
    logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic        result_valid;
    logic        result_kind;
    logic signed [15:0] out_w, out_x, out_y, out_z;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Predictor copy of the extrinsic
    logic [47:0]        ext_row [3];
    logic signed [31:0] ext_off [3];
    logic               twist_on;

    body_pose_t  expected_q[$];
    table_row_t  directed_rows[$];
    int          mismatch_cnt;
    int          bad_cnt;

    pose_frame_transform u_dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .kind(kind),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .result_valid(result_valid), .result_kind(result_kind),
        .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Shift right, rounding half away from zero
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int s);
        logic [63:0] m;
        m = (mag64(v) + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] ext_entry(input int j, input int k);
        logic [47:0] row;
        row = ext_row[j];
        return 64'($signed(row[47 - 16 * k -: 16]));
    endfunction

    // Body-frame pose or rotated twist for one command; returns 0 if dropped
    function automatic bit body_frame_of(input pose_cmd_t c, output body_pose_t r);
        logic signed [63:0] v[3], q[4], num[3][3], rm[3][3], bm[3][3], cs[4];
        logic signed [63:0] acc, tr;
        logic [63:0] n, n2, sq, m;
        int i, j, k;
        v[0] = 64'($signed(c.vx));
        v[1] = 64'($signed(c.vy));
        v[2] = 64'($signed(c.vz));
        r.kind = c.kind;
        if (c.kind == KIND_VEC)
        begin
            r.w = 0; r.x = 0; r.y = 0; r.z = 0;
            for (j = 0; j < 3; j++)
            begin
                acc = v[j];
                if (twist_on)
                begin
                    acc = 0;
                    for (k = 0; k < 3; k++)
                        acc += ext_entry(j, k) * v[k];
                    acc = clip32(round_shift(acc, 14));
                end
                if (j == 0) r.px = acc[31:0];
                else if (j == 1) r.py = acc[31:0];
                else r.pz = acc[31:0];
            end
            return 1;
        end
        q[0] = 64'($signed(c.qw)); q[1] = 64'($signed(c.qx));
        q[2] = 64'($signed(c.qy)); q[3] = 64'($signed(c.qz));
        n = q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
        if (n == 0)
            return 0;
        num[0][0] = q[0]*q[0] + q[1]*q[1] - q[2]*q[2] - q[3]*q[3];
        num[1][1] = q[0]*q[0] - q[1]*q[1] + q[2]*q[2] - q[3]*q[3];
        num[2][2] = q[0]*q[0] - q[1]*q[1] - q[2]*q[2] + q[3]*q[3];
        num[0][1] = 2 * (q[1]*q[2] - q[0]*q[3]);
        num[0][2] = 2 * (q[1]*q[3] + q[0]*q[2]);
        num[1][0] = 2 * (q[1]*q[2] + q[0]*q[3]);
        num[1][2] = 2 * (q[2]*q[3] - q[0]*q[1]);
        num[2][0] = 2 * (q[1]*q[3] - q[0]*q[2]);
        num[2][1] = 2 * (q[2]*q[3] + q[0]*q[1]);
        // Normalize to Q.30
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
            begin
                m = ((mag64(num[i][j]) << 31) + n) / (n * 2);
                rm[i][j] = num[i][j][63] ? -$signed(m) : $signed(m);
            end
        // Compose with transposed extrinsic, Q.24
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
            begin
                acc = 0;
                for (k = 0; k < 3; k++)
                    acc += rm[i][k] * ext_entry(j, k);
                bm[i][j] = round_shift(acc, 20);
            end
        for (i = 0; i < 3; i++)
        begin
            acc = 0;
            for (k = 0; k < 3; k++)
                acc += bm[i][k] * 64'(ext_off[k]);
            acc = clip32(v[i] - round_shift(acc, 24));
            if (i == 0) r.px = acc[31:0];
            else if (i == 1) r.py = acc[31:0];
            else r.pz = acc[31:0];
        end
        // Trace or largest-diagonal quaternion extraction
        tr = bm[0][0] + bm[1][1] + bm[2][2];
        if (tr > 0)
        begin
            cs[0] = tr + 64'(B_ONE);
            cs[1] = bm[2][1] - bm[1][2];
            cs[2] = bm[0][2] - bm[2][0];
            cs[3] = bm[1][0] - bm[0][1];
        end
        else
        begin
            i = 0;
            if (bm[1][1] > bm[0][0]) i = 1;
            if (bm[2][2] > bm[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            cs[1 + i] = bm[i][i] - bm[j][j] - bm[k][k] + 64'(B_ONE);
            cs[0] = bm[k][j] - bm[j][k];
            cs[1 + j] = bm[j][i] + bm[i][j];
            cs[1 + k] = bm[k][i] + bm[i][k];
        end
        n2 = 0;
        for (i = 0; i < 4; i++)
            n2 += mag64(cs[i]) * mag64(cs[i]);
        sq = int_sqrt(n2);
        r.kind = KIND_POSE;
        if (sq == 0)
        begin
            r.w = 16'sd16384; r.x = 0; r.y = 0; r.z = 0;
            return 1;
        end
        for (i = 0; i < 4; i++)
        begin
            m = ((mag64(cs[i]) << 15) + sq) / (2 * sq);
            if (m > 16384)
                m = 16384;
            acc = cs[i][63] ? -$signed(m) : $signed(m);
            if (i == 0) r.w = acc[15:0];
            else if (i == 1) r.x = acc[15:0];
            else if (i == 2) r.y = acc[15:0];
            else r.z = acc[15:0];
        end
        return 1;
    endfunction

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        body_pose_t e;
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
            begin
                bad_cnt++;
                if (mismatch_cnt++ < 10)
                    $display("unexpected result beat at %0t", $realtime);
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.kind !== result_kind || e.w !== out_w || e.x !== out_x ||
                    e.y !== out_y || e.z !== out_z || e.px !== pos_x ||
                    e.py !== pos_y || e.pz !== pos_z)
                begin
                    bad_cnt++;
                    if (mismatch_cnt++ < 10)
                        $display("mismatch exp k%0d q(%0d %0d %0d %0d) p(%0d %0d %0d) got k%0d q(%0d %0d %0d %0d) p(%0d %0d %0d)",
                                 e.kind, $signed(e.w), $signed(e.x), $signed(e.y),
                                 $signed(e.z), $signed(e.px), $signed(e.py),
                                 $signed(e.pz), result_kind, out_w, out_x, out_y,
                                 out_z, pos_x, pos_y, pos_z);
                end
            end
        end
    end

    // Write one register over APB and mirror it
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = 6'(int'(idx) * 8); pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_ROT_ROW0:  ext_row[0] = val[47:0];
            REG_ROT_ROW1:  ext_row[1] = val[47:0];
            REG_ROT_ROW2:  ext_row[2] = val[47:0];
            REG_OFFSET_X:  ext_off[0] = val[31:0];
            REG_OFFSET_Y:  ext_off[1] = val[31:0];
            REG_OFFSET_Z:  ext_off[2] = val[31:0];
            REG_ROT_TWIST: twist_on = val[0];
            default: ;
        endcase
    endtask

    // Drive one command beat and wait for acceptance
    task automatic send_cmd(input pose_cmd_t c, input bit known, input body_pose_t r);
        body_pose_t p;
        kind = c.kind;
        quat_w = c.qw; quat_x = c.qx; quat_y = c.qy; quat_z = c.qz;
        vec_x = c.vx; vec_y = c.vy; vec_z = c.vz;
        start = 1'b1;
        do @(posedge clk); while (busy);
        if (body_frame_of(c, p))
            expected_q.push_back(known ? r : p);
        @(negedge clk);
    endtask

    // Hold until the pipeline has drained
    task automatic drain();
        int guard;
        guard = 0;
        while (expected_q.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_field32();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 200000)) - 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_field16();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pose_cmd_t rand_cmd();
        pose_cmd_t c;
        c.kind = ($urandom_range(0, 3) == 0) ? KIND_VEC : KIND_POSE;
        c.qw = rand_field16(); c.qx = rand_field16();
        c.qy = rand_field16(); c.qz = rand_field16();
        if ($urandom_range(0, 30) == 0)
        begin
            c.qw = 0; c.qx = 0; c.qy = 0; c.qz = 0;
        end
        c.vx = rand_field32(); c.vy = rand_field32(); c.vz = rand_field32();
        return c;
    endfunction

    function automatic logic [47:0] rand_row();
        logic [47:0] row;
        case ($urandom_range(0, 3))
            0: row = {16'h7fff, 16'h8000, 16'h7fff};
            1: row = {16'h0000, 16'h0000, 16'h0000};
            default: row = {16'($urandom), 16'($urandom), 16'($urandom)};
        endcase
        return row;
    endfunction

    function automatic pose_cmd_t mk(input logic k, input logic [15:0] w, input logic [15:0] x,
                                     input logic [15:0] y, input logic [15:0] z,
                                     input logic [31:0] px, input logic [31:0] py,
                                     input logic [31:0] pz);
        pose_cmd_t c;
        c.kind = k; c.qw = w; c.qx = x; c.qy = y; c.qz = z;
        c.vx = px; c.vy = py; c.vz = pz;
        return c;
    endfunction

    function automatic body_pose_t res(input logic k, input logic [15:0] w,
                                       input logic [31:0] px, input logic [31:0] py,
                                       input logic [31:0] pz);
        body_pose_t r;
        r.kind = k; r.w = w; r.x = 0; r.y = 0; r.z = 0;
        r.px = px; r.py = py; r.pz = pz;
        return r;
    endfunction

    task automatic add_row(input pose_cmd_t c, input bit known, input body_pose_t r);
        table_row_t t;
        t.cmd = c; t.known = known; t.res = r;
        directed_rows.push_back(t);
    endtask

    // Random phase under the current extrinsic with sender bursts
    task automatic random_phase(input int count);
        body_pose_t dummy;
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
            begin
                start = 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
                burst = $urandom_range(1, 20);
            end
            send_cmd(rand_cmd(), 0, dummy);
            burst--;
        end
        start = 1'b0;
    endtask

    initial
    begin
        body_pose_t none;
        rst_n = 1'b0;
        start = 1'b0; kind = 1'b0;
        quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0;
        vec_x = 0; vec_y = 0; vec_z = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = 0; pwdata = 0;
        mismatch_cnt = 0; bad_cnt = 0;
        none = res(KIND_POSE, 0, 0, 0, 0);
        ext_row[0] = 48'h4000_0000_0000;
        ext_row[1] = 48'h0000_4000_0000;
        ext_row[2] = 48'h0000_0000_4000;
        ext_off[0] = 0; ext_off[1] = 0; ext_off[2] = 0;
        twist_on = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed beats under the reset extrinsic: identity, zero quaternion,
        // extremes, unrotated twist
        add_row(mk(KIND_POSE, 16'sd16384, 0, 0, 0, 32'd5, -32'sd7, 32'd9), 1,
                res(KIND_POSE, 16'sd16384, 32'd5, -32'sd7, 32'd9));
        add_row(mk(KIND_POSE, 0, 0, 0, 0, 32'd1, 32'd2, 32'd3), 0, none);
        add_row(mk(KIND_VEC, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                   32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff), 1,
                res(KIND_VEC, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
        add_row(mk(KIND_POSE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                   32'h7fff_ffff, 32'h8000_0000, 0), 0, none);
        add_row(mk(KIND_POSE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0), 0, none);
        add_row(mk(KIND_POSE, 0, 16'sd16384, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(KIND_POSE, 0, 0, 16'sd16384, 0, 0, 0, 0), 0, none);
        add_row(mk(KIND_POSE, 0, 0, 0, 16'h8000, 0, 0, 0), 0, none);
        add_row(mk(KIND_POSE, 16'sd1, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(mk(KIND_POSE, 0, 0, 0, 16'sd1, 0, 0, 0), 0, none);
        add_row(mk(KIND_POSE, 16'h8000, 16'h7fff, 0, 16'sd3, 32'd1, 32'd1, 32'd1), 0, none);
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].known, directed_rows[i].res);
        start = 1'b0;
        drain();

        // Degenerate extrinsic with large offsets and twist rotation on
        write_reg(REG_ROT_ROW0, 0);
        write_reg(REG_ROT_ROW1, 0);
        write_reg(REG_ROT_ROW2, 0);
        write_reg(REG_OFFSET_X, 64'h7fff_ffff);
        write_reg(REG_OFFSET_Y, 64'h8000_0000);
        write_reg(REG_OFFSET_Z, 64'hffff_ffff);
        write_reg(REG_ROT_TWIST, 1);
        send_cmd(mk(KIND_POSE, 16'sd16384, 0, 0, 0, 32'd10, 32'd20, 32'd30), 0, none);
        send_cmd(mk(KIND_VEC, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'd5), 1,
                 res(KIND_VEC, 0, 0, 0, 0));
        start = 1'b0;
        drain();

        // Extreme extrinsic entries, then random settings per phase
        write_reg(REG_ROT_ROW0, 64'h7fff_8000_7fff);
        write_reg(REG_ROT_ROW1, 64'h8000_7fff_8000);
        write_reg(REG_ROT_ROW2, 64'hffff_ffff_ffff);
        random_phase(50);
        drain();
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_ROT_ROW0, {16'h0, rand_row()});
            write_reg(REG_ROT_ROW1, {16'h0, rand_row()});
            write_reg(REG_ROT_ROW2, {16'h0, rand_row()});
            write_reg(REG_OFFSET_X, {32'h0, rand_field32()});
            write_reg(REG_OFFSET_Y, {32'h0, rand_field32()});
            write_reg(REG_OFFSET_Z, {32'h0, rand_field32()});
            write_reg(REG_ROT_TWIST, 64'($urandom_range(0, 1)));
            random_phase(50);
            drain();
        end

        if (bad_cnt == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
rtl/pft_pkg.sv
rtl/pose_frame_transform.sv
dv/pose_frame_transform_test.sv
